FILE: design/dedrec_pkg.sv
// ----------------------------------------------------------------------------
// dedrec_pkg
// Shared types and constants for the deduplicating record table sorter.
// ----------------------------------------------------------------------------
package dedrec_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMIT     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [6:0]  first;
    logic [6:0]  second;
    logic        category;
  } rec_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    rec_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_INS_END,
    S_EMPTY,
    S_SORT_LOAD,
    S_SORT_CUR,
    S_SORT_CMP,
    S_SORT_PUT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

endpackage

FILE: design/dedrec_mem.sv
// ----------------------------------------------------------------------------
// dedrec_mem
// Record storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dedrec_mem (
  input  logic               clk,
  input  dedrec_pkg::mem_req_t req,
  output dedrec_pkg::rec_t   rd_data
);
  import dedrec_pkg::*;

  rec_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: design/dedrec_cmp.sv
// ----------------------------------------------------------------------------
// dedrec_cmp
// Sort order compare: high when record a must come strictly before b.
// ----------------------------------------------------------------------------
module dedrec_cmp (
  input  logic             mode,
  input  dedrec_pkg::rec_t a,
  input  dedrec_pkg::rec_t b,
  output logic             ahead
);
  import dedrec_pkg::*;

  logic [7:0] total_a;
  logic [7:0] total_b;

  assign total_a = {1'b0, a.first} + {1'b0, a.second};
  assign total_b = {1'b0, b.first} + {1'b0, b.second};

  always_comb begin
    if (!mode) begin
      ahead = total_a > total_b;
    end else if (a.first != b.first) begin
      ahead = a.first > b.first;
    end else begin
      ahead = a.second > b.second;
    end
  end

endmodule

FILE: design/dedrec_ctrl.sv
// ----------------------------------------------------------------------------
// dedrec_ctrl
// Sequencer: duplicate scan and append, in-place insertion sort over the
// record memory, ordered readout into the output register.
// ----------------------------------------------------------------------------
module dedrec_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [15:0]          record_id,
  input  logic [6:0]           first_score,
  input  logic [6:0]           second_score,
  input  logic                 category,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [15:0]          out_id,
  output logic [6:0]           out_first,
  output logic [6:0]           out_second,
  output logic [7:0]           out_total,
  output logic                 out_category,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 sort_mode,
  output logic                 mode,
  output dedrec_pkg::rec_t     cur_rec,
  input  logic                 ahead,
  output dedrec_pkg::mem_req_t mem_req,
  input  dedrec_pkg::rec_t     rd_data
);
  import dedrec_pkg::*;

  state_t            state;
  state_t            state_next;
  state_t            sort_adv;
  rec_t              cur;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] j;
  logic              dup;

  logic              at_last;
  logic              match;
  logic              out_free;
  logic              full;
  logic              out_load;
  status_t           load_status;
  logic              load_emit;
  logic              load_last;

  assign at_last  = CNT_W'(ptr) == (count - CNT_W'(1));
  assign match    = rd_data.id == cur.id;
  assign out_free = !out_valid || out_ready;
  assign full     = count == CNT_W'(CAPACITY);
  assign sort_adv = at_last ? S_EMIT_RD : S_SORT_LOAD;
  assign cur_rec  = cur;
  // mode only changes between items
  assign cfg_ready = (state == S_IDLE) && !in_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_INSERT) begin
            state_next = (count == '0) ? S_INS_END : S_SCAN;
          end else if (count == '0) begin
            state_next = S_EMPTY;
          end else if (count == CNT_W'(1)) begin
            state_next = S_EMIT_RD;
          end else begin
            state_next = S_SORT_LOAD;
          end
        end
      end
      S_SCAN:      if (at_last) state_next = S_INS_END;
      S_INS_END:   if (out_free) state_next = S_IDLE;
      S_EMPTY:     if (out_free) state_next = S_IDLE;
      S_SORT_LOAD: state_next = S_SORT_CUR;
      S_SORT_CUR:  state_next = S_SORT_CMP;
      S_SORT_CMP: begin
        if (!ahead) begin
          state_next = sort_adv;
        end else if (j == ADDR_W'(1)) begin
          state_next = S_SORT_PUT;
        end
      end
      S_SORT_PUT:  state_next = sort_adv;
      S_EMIT_RD:   state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        if (out_free) begin
          state_next = at_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = j;
    mem_req.wr_data = cur;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = ptr;
    out_load        = 1'b0;
    load_status     = ST_INSERTED;
    load_emit       = 1'b0;
    load_last       = 1'b1;
    case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        mem_req.rd_en   = in_valid && (operation == OP_INSERT) && (count != '0);
        mem_req.rd_addr = '0;
      end
      S_SCAN: begin
        mem_req.rd_en   = !at_last;
        mem_req.rd_addr = ptr + ADDR_W'(1);
      end
      S_INS_END: begin
        out_load = out_free;
        if (dup) begin
          load_status = ST_DUP;
        end else if (full) begin
          load_status = ST_FULL;
        end else begin
          load_status     = ST_INSERTED;
          mem_req.wr_en   = out_free;
          mem_req.wr_addr = ADDR_W'(count);
        end
      end
      S_EMPTY: begin
        out_load    = out_free;
        load_status = ST_EMPTY;
      end
      S_SORT_LOAD: begin
        mem_req.rd_en = 1'b1;
      end
      S_SORT_CUR: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ptr - ADDR_W'(1);
      end
      S_SORT_CMP: begin
        mem_req.wr_en = 1'b1;
        if (ahead) begin
          mem_req.wr_data = rd_data;
          mem_req.rd_en   = j != ADDR_W'(1);
          mem_req.rd_addr = j - ADDR_W'(2);
        end
      end
      S_SORT_PUT: begin
        mem_req.wr_en = 1'b1;
      end
      S_EMIT_RD: begin
        mem_req.rd_en = 1'b1;
      end
      S_EMIT_LD: begin
        out_load    = out_free;
        load_status = ST_EMIT;
        load_emit   = 1'b1;
        load_last   = at_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      mode      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mode <= sort_mode;
      end
      if (state == S_INS_END && out_free && !dup && !full) begin
        count <= count + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur.id       <= record_id;
          cur.first    <= first_score;
          cur.second   <= second_score;
          cur.category <= category;
          dup          <= 1'b0;
          ptr          <= (operation == OP_DUMP && count > CNT_W'(1)) ? ADDR_W'(1) : '0;
        end
      end
      S_SCAN: begin
        dup <= dup | match;
        ptr <= ptr + ADDR_W'(1);
      end
      S_SORT_CUR: begin
        cur <= rd_data;
        j   <= ptr;
      end
      S_SORT_CMP: begin
        if (ahead) begin
          j <= j - ADDR_W'(1);
        end else begin
          ptr <= at_last ? '0 : ptr + ADDR_W'(1);
        end
      end
      S_SORT_PUT: begin
        ptr <= at_last ? '0 : ptr + ADDR_W'(1);
      end
      S_EMIT_LD: begin
        if (out_free) begin
          ptr <= ptr + ADDR_W'(1);
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= load_status;
      last   <= load_last;
      if (load_emit) begin
        out_id       <= rd_data.id;
        out_first    <= rd_data.first;
        out_second   <= rd_data.second;
        out_total    <= {1'b0, rd_data.first} + {1'b0, rd_data.second};
        out_category <= rd_data.category;
      end else begin
        out_id       <= '0;
        out_first    <= '0;
        out_second   <= '0;
        out_total    <= '0;
        out_category <= 1'b0;
      end
    end
  end

endmodule

FILE: design/dedup_record_table_sorter.sv
// Insert: the stored ids are scanned for a duplicate, one stored id compared per cycle.
// Dump: insertion sort in the record memory, each record loaded, compared and
// shifted past the records it must precede, then the records are emitted in order.
// One item at a time; the output register lets the next item start early.
// Synchronous reset clears the record count, the registered sort mode and the output valid;
// the record memory is not cleared.
// ----------------------------------------------------------------------------
// dedup_record_table_sorter
// Deduplicating record table with a two-mode stable sorted dump.
// ----------------------------------------------------------------------------
module dedup_record_table_sorter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] record_id,
  input  logic [6:0]  first_score,
  input  logic [6:0]  second_score,
  input  logic        category,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] out_id,
  output logic [6:0]  out_first,
  output logic [6:0]  out_second,
  output logic [7:0]  out_total,
  output logic        out_category,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        sort_mode
);
  import dedrec_pkg::*;

  mem_req_t mem_req;
  rec_t     rd_data;
  rec_t     cur_rec;
  logic     mode;
  logic     ahead;

  dedrec_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  dedrec_cmp u_cmp (
    .mode  (mode),
    .a     (cur_rec),
    .b     (rd_data),
    .ahead (ahead)
  );

  dedrec_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .record_id    (record_id),
    .first_score  (first_score),
    .second_score (second_score),
    .category     (category),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_id       (out_id),
    .out_first    (out_first),
    .out_second   (out_second),
    .out_total    (out_total),
    .out_category (out_category),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sort_mode    (sort_mode),
    .mode         (mode),
    .cur_rec      (cur_rec),
    .ahead        (ahead),
    .mem_req      (mem_req),
    .rd_data      (rd_data)
  );

endmodule

FILE: design/dedrec_chk.sv
// ----------------------------------------------------------------------------
// dedrec_chk
// Port-level checks for the record table sorter, bound to the top level.
// ----------------------------------------------------------------------------
module dedrec_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] out_id,
  input logic [6:0]  out_first,
  input logic [6:0]  out_second,
  input logic [7:0]  out_total,
  input logic        out_category,
  input logic        last
);
  import dedrec_pkg::*;

  // in_ready is low in the cycle after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(out_total) && $stable(last))
    else $error("stalled result changed");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_EMIT |-> last && out_id == '0 && out_total == '0
      && out_category == 1'b0)
    else $error("status result carries record data or lacks last");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMIT |->
      out_total == ({1'b0, out_first} + {1'b0, out_second}))
    else $error("emitted total does not match the scores");

endmodule

bind dedup_record_table_sorter dedrec_chk u_chk (.*);
